@@ rtl/bds_pkg.sv @@
// Package for the 2x2 box downsampler: shared types, register indexes and widths.
// Used by bds_front, bds_back and box_downsample_2x2; depends on nothing else.

package bds_pkg;

  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned LANE_W    = CHAN_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

  // Operation that the back end carries out for one command.
  typedef enum logic [1:0] {
    OP_PASS  = 2'd0,
    OP_WRITE = 2'd1,
    OP_AVG   = 2'd2
  } op_e;

  // Four 9-bit lanes, red in the low lane and alpha in the high lane.
  typedef struct packed {
    logic [LANE_W-1:0] alpha;
    logic [LANE_W-1:0] blue;
    logic [LANE_W-1:0] green;
    logic [LANE_W-1:0] red;
  } sums_t;

  typedef struct packed {
    op_e   op;
    logic  last;
    sums_t sums;
  } cmd_t;

  typedef struct packed {
    logic              last;
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } res_t;

endpackage

@@ rtl/box_downsample_2x2.sv @@
// Top level of the 2x2 box-filter downsampler for RGBA8 pixel streams.
// Instantiates bds_front, bds_fifo and bds_back; uses types from bds_pkg.
//
// Usage. Pixels of a frame enter in raster order through a queue-style input:
// a transaction completes at a clock edge with push_i high and full_o low.
// When both frame dimensions are even, each 2x2 block of pixels yields one
// output pixel whose four channels are the truncated average of the block;
// it becomes available when the lower-right pixel of the block arrives.
// When either dimension is odd, every pixel passes through unchanged.
// frame_last_o marks the final output pixel of a frame. Results leave through
// a queue-style output: the oldest result is on the ports while empty_o is
// low, and a transaction completes at an edge with pop_i high.
// Configuration writes (cfg_valid_i with cfg_ready_o, which is always high)
// set the frame width or height and restart the frame; issue them only while
// the block is idle. Reset sets both dimensions to 256 and restarts the frame.
// Throughput is one pixel per cycle while full_o is low. A result reaches the
// output ports through the command queue and then the back-end stage that
// registers the command and the line-store read; the final add feeds the
// result queue directly.
// When the receiver stalls, the result queue fills, the back end stops taking
// commands, and once the command queue fills full_o rises; nothing is lost.
// The line store holds MAX_WIDTH/2 pair-sum entries and needs no clearing.

module box_downsample_2x2 #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bds_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bds_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [bds_pkg::CHAN_W-1:0]    red_i,
  input  logic [bds_pkg::CHAN_W-1:0]    green_i,
  input  logic [bds_pkg::CHAN_W-1:0]    blue_i,
  input  logic [bds_pkg::CHAN_W-1:0]    alpha_i,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic [bds_pkg::CHAN_W-1:0]    out_red_o,
  output logic [bds_pkg::CHAN_W-1:0]    out_green_o,
  output logic [bds_pkg::CHAN_W-1:0]    out_blue_o,
  output logic [bds_pkg::CHAN_W-1:0]    out_alpha_o,
  output logic                          frame_last_o
);

  localparam int unsigned LineDepth = MAX_WIDTH / 2;
  localparam int unsigned AddrW     = (LineDepth > 1) ? $clog2(LineDepth) : 1;
  localparam int unsigned CmdDepth  = 4;
  localparam int unsigned OutDepth  = 4;
  localparam int unsigned CmdW      = $bits(bds_pkg::cmd_t) + AddrW;
  localparam int unsigned ResW      = $bits(bds_pkg::res_t);
  localparam int unsigned OutCntW   = $clog2(OutDepth + 1);

  logic                       accept, cfg_we;
  logic                       cmd_push, cmd_pop, cmd_empty;
  bds_pkg::cmd_t              fe_cmd, be_cmd;
  logic [AddrW-1:0]           fe_addr, be_addr;
  logic [CmdW-1:0]            cmd_q_out;
  logic [$clog2(CmdDepth+1)-1:0] cmd_count;
  logic                       res_push, out_full;
  bds_pkg::res_t              be_res, out_res;
  logic [ResW-1:0]            out_q_out;
  logic [OutCntW-1:0]         out_count;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign accept      = push_i && !full_o;

  bds_front #(
    .LINE_DEPTH (LineDepth),
    .ADDR_W     (AddrW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .alpha_i    (alpha_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (fe_cmd),
    .cmd_addr_o (fe_addr)
  );

  // Command queue between the front and back ends.
  bds_fifo #(
    .WIDTH (CmdW),
    .DEPTH (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  ({fe_addr, fe_cmd}),
    .full_o  (full_o),
    .pop_i   (cmd_pop),
    .data_o  (cmd_q_out),
    .empty_o (cmd_empty),
    .count_o (cmd_count)
  );

  assign be_cmd  = cmd_q_out[$bits(bds_pkg::cmd_t)-1:0];
  assign be_addr = cmd_q_out[CmdW-1:$bits(bds_pkg::cmd_t)];

  bds_back #(
    .LINE_DEPTH (LineDepth),
    .ADDR_W     (AddrW),
    .OUT_DEPTH  (OutDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (be_cmd),
    .cmd_addr_i  (be_addr),
    .cmd_pop_o   (cmd_pop),
    .out_count_i (out_count),
    .res_push_o  (res_push),
    .res_o       (be_res)
  );

  // Result queue; the back end never pushes into it while it is full, so
  // out_full is informational only and cmd_count is kept for visibility.
  bds_fifo #(
    .WIDTH (ResW),
    .DEPTH (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push && !out_full && (cmd_count <= $bits(cmd_count)'(CmdDepth))),
    .data_i  (be_res),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .data_o  (out_q_out),
    .empty_o (empty_o),
    .count_o (out_count)
  );

  assign out_res      = out_q_out;
  assign out_red_o    = out_res.red;
  assign out_green_o  = out_res.green;
  assign out_blue_o   = out_res.blue;
  assign out_alpha_o  = out_res.alpha;
  assign frame_last_o = out_res.last;

endmodule

@@ rtl/bds_fifo.sv @@
// Small first-in first-out queue with an occupancy count.
// Generic storage used between the downsampler stages; no package dependency.

module bds_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/bds_front.sv @@
// Front end of the downsampler: frame registers, position counters, held pixel
// and pair sums; classifies each pixel into a back-end command. Uses bds_pkg.

module bds_front #(
  parameter int unsigned LINE_DEPTH = 2048,
  parameter int unsigned ADDR_W     = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bds_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bds_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic                          accept_i,
  input  logic [bds_pkg::CHAN_W-1:0]    red_i,
  input  logic [bds_pkg::CHAN_W-1:0]    green_i,
  input  logic [bds_pkg::CHAN_W-1:0]    blue_i,
  input  logic [bds_pkg::CHAN_W-1:0]    alpha_i,
  output logic                          cmd_push_o,
  output bds_pkg::cmd_t                 cmd_o,
  output logic [ADDR_W-1:0]             cmd_addr_o
);

  localparam int unsigned DimW = bds_pkg::DIM_W;
  localparam int unsigned ChW  = bds_pkg::CHAN_W;

  logic [DimW-1:0]   width_q, width_d, height_q, height_d;
  logic [DimW-1:0]   col_q, col_d, row_q, row_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [4*ChW-1:0]  held_q, held_d;
  logic [DimW-1:0]   w_eff, h_eff;
  logic              col_end, row_end, pass_mode;
  logic [4*ChW-1:0]  px;
  bds_pkg::sums_t    pair, raw;

  assign px    = {alpha_i, blue_i, green_i, red_i};
  assign w_eff = (width_q == '0) ? DimW'(1) : width_q;
  assign h_eff = (height_q == '0) ? DimW'(1) : height_q;

  assign col_end   = ({1'b0, col_q} + (DimW+1)'(1)) >= {1'b0, w_eff};
  assign row_end   = ({1'b0, row_q} + (DimW+1)'(1)) >= {1'b0, h_eff};
  assign pass_mode = w_eff[0] || h_eff[0];

  assign pair.red   = {1'b0, held_q[ChW-1:0]}       + {1'b0, red_i};
  assign pair.green = {1'b0, held_q[2*ChW-1:ChW]}   + {1'b0, green_i};
  assign pair.blue  = {1'b0, held_q[3*ChW-1:2*ChW]} + {1'b0, blue_i};
  assign pair.alpha = {1'b0, held_q[4*ChW-1:3*ChW]} + {1'b0, alpha_i};

  assign raw.red   = {1'b0, red_i};
  assign raw.green = {1'b0, green_i};
  assign raw.blue  = {1'b0, blue_i};
  assign raw.alpha = {1'b0, alpha_i};

  // Classify: odd frames pass every pixel, even columns are held, odd columns
  // either store a pair sum (even rows) or complete a block (odd rows).
  always_comb begin
    cmd_push_o   = 1'b0;
    cmd_o.op     = bds_pkg::OP_PASS;
    cmd_o.last   = col_end && row_end;
    cmd_o.sums   = raw;
    cmd_addr_o   = addr_q;
    held_d       = held_q;
    if (accept_i) begin
      if (pass_mode) begin
        cmd_push_o = 1'b1;
      end else if (!col_q[0]) begin
        held_d = px;
      end else begin
        cmd_push_o = 1'b1;
        cmd_o.sums = pair;
        cmd_o.op   = row_q[0] ? bds_pkg::OP_AVG : bds_pkg::OP_WRITE;
      end
    end
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    addr_d   = addr_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bds_pkg::REG_FRAME_WIDTH: begin
          width_d = cfg_data_i;
          col_d   = '0;
          row_d   = '0;
          addr_d  = '0;
        end
        bds_pkg::REG_FRAME_HEIGHT: begin
          height_d = cfg_data_i;
          col_d    = '0;
          row_d    = '0;
          addr_d   = '0;
        end
        default: begin
        end
      endcase
    end else if (accept_i) begin
      if (col_end) begin
        col_d  = '0;
        addr_d = '0;
        row_d  = row_end ? '0 : row_q + DimW'(1);
      end else begin
        col_d = col_q + DimW'(1);
        if (col_q[0]) begin
          // Line address wraps at the store depth for frames wider than it.
          addr_d = (addr_q == ADDR_W'(LINE_DEPTH - 1)) ? '0 : addr_q + ADDR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bds_pkg::DIM_RESET;
      height_q <= bds_pkg::DIM_RESET;
      col_q    <= '0;
      row_q    <= '0;
      addr_q   <= '0;
      held_q   <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      addr_q   <= addr_d;
      held_q   <= held_d;
    end
  end

endmodule

@@ rtl/bds_back.sv @@
// Back end of the downsampler: the line store of pair sums and the final
// block average; pushes finished pixels into the result queue. Uses bds_pkg.

module bds_back #(
  parameter int unsigned LINE_DEPTH = 2048,
  parameter int unsigned ADDR_W     = 11,
  parameter int unsigned OUT_DEPTH  = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cmd_empty_i,
  input  bds_pkg::cmd_t                      cmd_i,
  input  logic [ADDR_W-1:0]                  cmd_addr_i,
  output logic                               cmd_pop_o,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_count_i,
  output logic                               res_push_o,
  output bds_pkg::res_t                      res_o
);

  localparam int unsigned CntW  = $clog2(OUT_DEPTH + 1);
  localparam int unsigned LaneW = bds_pkg::LANE_W;

  logic [$bits(bds_pkg::sums_t)-1:0] line_mem [LINE_DEPTH];
  bds_pkg::sums_t upper_q;
  bds_pkg::cmd_t  s2_cmd_q;
  logic           s2_valid_q;
  logic           room;
  logic [LaneW:0] sum_r, sum_g, sum_b, sum_a;

  // Issue only when the result queue can still take the item in flight.
  assign room      = ({1'b0, out_count_i} + (CntW+1)'(s2_valid_q)) < (CntW+1)'(OUT_DEPTH);
  assign cmd_pop_o = !cmd_empty_i && room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= cmd_pop_o && (cmd_i.op != bds_pkg::OP_WRITE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      s2_cmd_q <= cmd_i;
      if (cmd_i.op == bds_pkg::OP_WRITE) begin
        line_mem[cmd_addr_i] <= cmd_i.sums;
      end
      if (cmd_i.op == bds_pkg::OP_AVG) begin
        upper_q <= line_mem[cmd_addr_i];
      end
    end
  end

  assign sum_r = {1'b0, upper_q.red}   + {1'b0, s2_cmd_q.sums.red};
  assign sum_g = {1'b0, upper_q.green} + {1'b0, s2_cmd_q.sums.green};
  assign sum_b = {1'b0, upper_q.blue}  + {1'b0, s2_cmd_q.sums.blue};
  assign sum_a = {1'b0, upper_q.alpha} + {1'b0, s2_cmd_q.sums.alpha};

  assign res_push_o = s2_valid_q;

  always_comb begin
    res_o.last = s2_cmd_q.last;
    unique case (s2_cmd_q.op)
      bds_pkg::OP_AVG: begin
        res_o.red   = sum_r[LaneW:2];
        res_o.green = sum_g[LaneW:2];
        res_o.blue  = sum_b[LaneW:2];
        res_o.alpha = sum_a[LaneW:2];
      end
      default: begin
        res_o.red   = s2_cmd_q.sums.red[LaneW-2:0];
        res_o.green = s2_cmd_q.sums.green[LaneW-2:0];
        res_o.blue  = s2_cmd_q.sums.blue[LaneW-2:0];
        res_o.alpha = s2_cmd_q.sums.alpha[LaneW-2:0];
      end
    endcase
  end

endmodule
